// File: rtl/core/rthsv_pkg.sv
// shared types and constants for the rgb to hsv converter
`timescale 1ns / 1ps

package rthsv_pkg;

  // field widths of the pixel and result beats
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 13;

  // default fixed point formats
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_FRAC_BITS_DEF = 12;

  // sector offsets in degrees
  localparam int DEG_60  = 60;
  localparam int DEG_120 = 120;
  localparam int DEG_240 = 240;
  localparam int DEG_360 = 360;

  // which channel holds the maximum
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

// File: rtl/core/rgb_to_hsv_convert_core.sv
// rgb to hsv converter: pipelined max/min, sector numerator and two long dividers
`timescale 1ns / 1ps

// usage
//   in channel: one rgb pixel per beat on red_byte, green_byte, blue_byte,
//   taken when in_valid is high and in_stall is low
//   out channel: hue_angle (degrees, HUE_FRAC_BITS fraction bits),
//   saturation_level (SAT_FRAC_BITS fraction bits) and value_level,
//   one result beat per pixel, in order
//   path: a pixel moves through stage a, the divider setup register, the
//   divider stages and the output register before out_valid rises
//   throughput: one pixel per cycle unless out_stall holds a result beat;
//   the depth is set by the restoring dividers, one quotient bit per stage
//   stalls: the whole pipeline freezes while a result beat waits under
//   out_stall, and in_stall is raised in that same cycle; bubbles freeze
//   with it, so a new pixel is taken whenever the output register is empty
//   or drains
//   reset: rst clears every stage valid bit; no pixel is in flight afterward
//   black and grey pixels give zero hue and saturation; a hue that rounds to
//   a full circle wraps to zero; results wider than the ports are truncated
module rgb_to_hsv_convert_core #(
  parameter int HUE_FRAC_BITS = rthsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rthsv_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // pixel channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rthsv_pkg::CHAN_W-1:0] red_byte,
  input  logic [rthsv_pkg::CHAN_W-1:0] green_byte,
  input  logic [rthsv_pkg::CHAN_W-1:0] blue_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rthsv_pkg::HUE_W-1:0]  hue_angle,
  output logic [rthsv_pkg::SAT_W-1:0]  saturation_level,
  output logic [rthsv_pkg::CHAN_W-1:0] value_level
);

  // quotient widths: hue quotient is twice the hue (one extra bit for rounding)
  localparam int QH     = HUE_FRAC_BITS + 10;
  localparam int QS     = SAT_FRAC_BITS + 2;
  localparam int NDIV   = (QH > QS) ? QH : QS;
  localparam int HUE_XW = (QH > rthsv_pkg::HUE_W) ? QH : rthsv_pkg::HUE_W;
  localparam int SAT_XW = (QS > rthsv_pkg::SAT_W) ? QS : rthsv_pkg::SAT_W;
  localparam logic [QH-1:0] HUE_FULL = QH'(rthsv_pkg::DEG_360) << HUE_FRAC_BITS;
  localparam logic [QS-1:0] SAT_ONE  = QS'(1) << SAT_FRAC_BITS;

  // one enable for the whole pipeline: move unless the result beat is held
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // stage a: max, min, spread, sector and signed channel difference
  // ---------------------------------------------------------------------
  logic                 r_ge_g, r_ge_b, g_ge_b;
  logic [7:0]           hi_c, lo_c;
  rthsv_pkg::sector_t   sec_c;
  logic signed [8:0]    diff_c;

  assign r_ge_g = red_byte >= green_byte;
  assign r_ge_b = red_byte >= blue_byte;
  assign g_ge_b = green_byte >= blue_byte;

  always_comb begin
    // ties go to red first, then green
    if (r_ge_g && r_ge_b) begin
      sec_c  = rthsv_pkg::SEC_RED;
      hi_c   = red_byte;
      diff_c = $signed({1'b0, green_byte}) - $signed({1'b0, blue_byte});
    end else if (g_ge_b) begin
      sec_c  = rthsv_pkg::SEC_GREEN;
      hi_c   = green_byte;
      diff_c = $signed({1'b0, blue_byte}) - $signed({1'b0, red_byte});
    end else begin
      sec_c  = rthsv_pkg::SEC_BLUE;
      hi_c   = blue_byte;
      diff_c = $signed({1'b0, red_byte}) - $signed({1'b0, green_byte});
    end
    if (!r_ge_g && !r_ge_b) begin
      lo_c = red_byte;
    end else if (!g_ge_b) begin
      lo_c = green_byte;
    end else begin
      lo_c = blue_byte;
    end
    if (r_ge_g && g_ge_b) begin
      lo_c = blue_byte;
    end else if (r_ge_b && !r_ge_g) begin
      lo_c = blue_byte;
    end
    if (!r_ge_g && !g_ge_b) begin
      lo_c = red_byte;
    end
    if (r_ge_b && !g_ge_b) begin
      lo_c = green_byte;
    end
    if (!r_ge_b && r_ge_g) begin
      lo_c = green_byte;
    end
    if (!r_ge_b && !r_ge_g) begin
      lo_c = red_byte;
    end
  end

  logic               a_vld;
  logic [7:0]         a_hi;
  logic [7:0]         a_spread;
  rthsv_pkg::sector_t a_sec;
  logic signed [8:0]  a_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_hi     <= hi_c;
      a_spread <= hi_c - lo_c;
      a_sec    <= sec_c;
      a_diff   <= diff_c;
    end
  end

  // ---------------------------------------------------------------------
  // stage b: hue numerator in degrees times spread, divider setup
  // ---------------------------------------------------------------------
  logic [16:0]        sx;
  logic [16:0]        base_term;
  logic signed [15:0] diff60;
  logic signed [17:0] num_w;
  logic [16:0]        num;

  assign sx     = 17'(a_spread);
  assign diff60 = 16'(a_diff) * 16'(rthsv_pkg::DEG_60);

  always_comb begin
    unique case (a_sec)
      rthsv_pkg::SEC_RED: begin
        // negative red-sector hue is lifted by a full circle
        base_term = a_diff[8] ? sx * 17'(rthsv_pkg::DEG_360) : '0;
      end
      rthsv_pkg::SEC_GREEN: base_term = sx * 17'(rthsv_pkg::DEG_120);
      rthsv_pkg::SEC_BLUE:  base_term = sx * 17'(rthsv_pkg::DEG_240);
      default:              base_term = '0;
    endcase
  end

  assign num_w = $signed({1'b0, base_term}) + 18'(diff60);
  assign num   = num_w[16:0];

  // divider stage arrays, index 0 is the setup register
  logic [7:0]    h_rem  [NDIV+1];
  logic [QH-1:0] h_pend [NDIV+1];
  logic [7:0]    s_rem  [NDIV+1];
  logic [QS-1:0] s_pend [NDIV+1];
  logic [7:0]    d_hi   [NDIV+1];
  logic [7:0]    d_spr  [NDIV+1];
  logic          d_zero [NDIV+1];
  logic          vld    [NDIV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= a_vld;
    end
  end

  // 2*num << frac over spread: top bits start as remainder, rest shift in
  always_ff @(posedge clk) begin
    if (adv) begin
      h_rem[0]  <= num[16:9];
      h_pend[0] <= {num[8:0], {(HUE_FRAC_BITS + 1){1'b0}}};
      s_rem[0]  <= {1'b0, a_spread[7:1]};
      s_pend[0] <= {a_spread[0], {(SAT_FRAC_BITS + 1){1'b0}}};
      d_hi[0]   <= a_hi;
      d_spr[0]  <= a_spread;
      d_zero[0] <= (a_spread == 8'd0);
    end
  end

  // ---------------------------------------------------------------------
  // restoring divider stages, one quotient bit each; the shorter divider
  // idles in the leading stages so both finish together
  // ---------------------------------------------------------------------
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [8:0] h_trial, s_trial;
    logic       h_ge, s_ge;

    assign h_trial = {h_rem[k-1], h_pend[k-1][QH-1]};
    assign s_trial = {s_rem[k-1], s_pend[k-1][QS-1]};
    assign h_ge    = h_trial >= {1'b0, d_spr[k-1]};
    assign s_ge    = s_trial >= {1'b0, d_hi[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_hi[k]   <= d_hi[k-1];
        d_spr[k]  <= d_spr[k-1];
        d_zero[k] <= d_zero[k-1];
        if (k > NDIV - QH) begin
          h_rem[k]  <= h_ge ? 8'(h_trial - {1'b0, d_spr[k-1]}) : h_trial[7:0];
          h_pend[k] <= {h_pend[k-1][QH-2:0], h_ge};
        end else begin
          h_rem[k]  <= h_rem[k-1];
          h_pend[k] <= h_pend[k-1];
        end
        if (k > NDIV - QS) begin
          s_rem[k]  <= s_ge ? 8'(s_trial - {1'b0, d_hi[k-1]}) : s_trial[7:0];
          s_pend[k] <= {s_pend[k-1][QS-2:0], s_ge};
        end else begin
          s_rem[k]  <= s_rem[k-1];
          s_pend[k] <= s_pend[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // output stage: round half up, wrap a full circle, force grey to zero
  // ---------------------------------------------------------------------
  logic [QH:0]   h_sum;
  logic [QH-1:0] h_rnd, h_wrap;
  logic [QS:0]   s_sum;
  logic [QS-1:0] s_rnd;

  assign h_sum  = {1'b0, h_pend[NDIV]} + 1'b1;
  assign h_rnd  = h_sum[QH:1];
  assign h_wrap = (h_rnd >= HUE_FULL) ? h_rnd - HUE_FULL : h_rnd;
  assign s_sum  = {1'b0, s_pend[NDIV]} + 1'b1;
  assign s_rnd  = s_sum[QS:1];

  logic [QH-1:0] hue_q;
  logic [QS-1:0] sat_q;
  logic [7:0]    val_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_q <= d_zero[NDIV] ? '0 : h_wrap;
      sat_q <= d_zero[NDIV] ? '0 : s_rnd;
      val_q <= d_hi[NDIV];
    end
  end

  logic [HUE_XW-1:0] hue_x;
  logic [SAT_XW-1:0] sat_x;

  assign hue_x            = HUE_XW'(hue_q);
  assign sat_x            = SAT_XW'(sat_q);
  assign hue_angle        = hue_x[rthsv_pkg::HUE_W-1:0];
  assign saturation_level = sat_x[rthsv_pkg::SAT_W-1:0];
  assign value_level      = val_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue_q < HUE_FULL)
    else $error("hue beyond a full circle");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sat_q <= SAT_ONE)
    else $error("saturation above one");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && val_q == 8'd0 |-> sat_q == '0 && hue_q == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat_q == '0 |-> hue_q == '0)
    else $error("grey pixel with nonzero hue");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld[0]) && $stable(vld[NDIV]) && $stable(a_vld))
    else $error("stage valid moved during a stall");

endmodule

// File: verif/rgb_to_hsv_convert_core_tb.sv
// self-checking testbench for the rgb to hsv converter core
`timescale 1ns / 1ps

module rgb_to_hsv_convert_core_tb;

  // default fixed point formats, also handed to the block
  localparam int HUE_FRAC = rthsv_pkg::HUE_FRAC_BITS_DEF;
  localparam int SAT_FRAC = rthsv_pkg::SAT_FRAC_BITS_DEF;

  // accept to out_valid, reckoned from the block's quotient widths
  localparam int PIPE_LATENCY =
    (((HUE_FRAC + 10) > (SAT_FRAC + 2)) ? (HUE_FRAC + 10) : (SAT_FRAC + 2)) + 2;

  // worst case is far below this: ~1650 pixels, gaps up to 8 per burst,
  // receiver stalling about half of the time at worst
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PIXELS = 1628;
  localparam int REPORT_MAX = 10;

  // one channel byte
  typedef logic [rthsv_pkg::CHAN_W-1:0] chan_t;

  // one result beat
  typedef struct packed {
    logic [rthsv_pkg::HUE_W-1:0]  hue;
    logic [rthsv_pkg::SAT_W-1:0]  sat;
    logic [rthsv_pkg::CHAN_W-1:0] val;
  } hsv_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [rthsv_pkg::CHAN_W-1:0] red_byte;
  logic [rthsv_pkg::CHAN_W-1:0] green_byte;
  logic [rthsv_pkg::CHAN_W-1:0] blue_byte;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [rthsv_pkg::HUE_W-1:0]  hue_angle;
  logic [rthsv_pkg::SAT_W-1:0]  saturation_level;
  logic [rthsv_pkg::CHAN_W-1:0] value_level;

  // hsv results still owed by the block, oldest first
  hsv_t pending_hsv[$];
  int   hsv_mismatches = 0;
  int   cycle_count = 0;

  // sender burst shaping
  int   burst_left = 0;

  // receiver stall pattern state
  int   stall_mode = 0;
  int   stall_left = 0;

  rgb_to_hsv_convert_core #(
    .HUE_FRAC_BITS(HUE_FRAC),
    .SAT_FRAC_BITS(SAT_FRAC)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .red_byte         (red_byte),
    .green_byte       (green_byte),
    .blue_byte        (blue_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hue_angle        (hue_angle),
    .saturation_level (saturation_level),
    .value_level      (value_level)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // round half up of num / den
  function automatic longint unsigned div_round_up(input longint unsigned num,
                                                   input longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // expected hue, saturation and value of one pixel
  function automatic hsv_t pixel_to_hsv(input chan_t r,
                                        input chan_t g,
                                        input chan_t b);
    longint unsigned    rr, gg, bb, hi, lo, spread, num, hue, sat, full;
    rthsv_pkg::sector_t sec;
    hsv_t               res;
    rr = 64'(r);
    gg = 64'(g);
    bb = 64'(b);
    // strict compares so ties go red, then green
    hi = rr;
    sec = rthsv_pkg::SEC_RED;
    if (gg > hi) begin
      hi = gg;
      sec = rthsv_pkg::SEC_GREEN;
    end
    if (bb > hi) begin
      hi = bb;
      sec = rthsv_pkg::SEC_BLUE;
    end
    lo = rr;
    if (gg < lo) lo = gg;
    if (bb < lo) lo = bb;
    spread = hi - lo;
    hue = 0;
    sat = 0;
    // black and grey pixels leave hue and saturation at zero
    if (spread != 0) begin
      full = longint'(rthsv_pkg::DEG_360) << HUE_FRAC;
      sat = div_round_up(spread << SAT_FRAC, hi);
      // numerator of hue in degrees over spread, kept nonnegative
      case (sec)
        rthsv_pkg::SEC_RED: begin
          if (gg >= bb) num = rthsv_pkg::DEG_60 * (gg - bb);
          else num = rthsv_pkg::DEG_360 * spread - rthsv_pkg::DEG_60 * (bb - gg);
        end
        rthsv_pkg::SEC_GREEN: begin
          num = rthsv_pkg::DEG_120 * spread + rthsv_pkg::DEG_60 * bb
                - rthsv_pkg::DEG_60 * rr;
        end
        default: begin
          num = rthsv_pkg::DEG_240 * spread + rthsv_pkg::DEG_60 * rr
                - rthsv_pkg::DEG_60 * gg;
        end
      endcase
      hue = div_round_up(num << HUE_FRAC, spread);
      // a full circle wraps to zero
      if (hue >= full) hue -= full;
    end
    res.hue = hue[rthsv_pkg::HUE_W-1:0];
    res.sat = sat[rthsv_pkg::SAT_W-1:0];
    res.val = hi[rthsv_pkg::CHAN_W-1:0];
    return res;
  endfunction

  // a channel within two steps of either rail
  function automatic chan_t near_rail_chan();
    chan_t step;
    step = chan_t'($urandom_range(0, 2));
    return ($urandom_range(0, 1) != 0) ? chan_t'(8'd255 - step) : step;
  endfunction

  // send one pixel and log its expected result once it is taken;
  // between most bursts the valid drops for a random gap
  task automatic push_pixel(input chan_t r,
                            input chan_t g,
                            input chan_t b);
    int gap;
    in_valid   <= 1'b1;
    red_byte   <= r;
    green_byte <= g;
    blue_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hsv.push_back(pixel_to_hsv(r, g, b));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      // a quarter of the bursts run straight on with no gap
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // corners of the rgb cube plus the one-lsb pixels
  task automatic test_extremes();
    push_pixel(8'd0,   8'd0,   8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0,   8'd0);
    push_pixel(8'd0,   8'd255, 8'd0);
    push_pixel(8'd0,   8'd0,   8'd255);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd0,   8'd255, 8'd255);
    push_pixel(8'd255, 8'd0,   8'd255);
    push_pixel(8'd1,   8'd0,   8'd0);
    push_pixel(8'd0,   8'd1,   8'd0);
    push_pixel(8'd0,   8'd0,   8'd1);
    push_pixel(8'd255, 8'd254, 8'd254);
  endtask

  // grey, ties for the maximum, every sector with both signs, hue near 360
  task automatic test_special_cases();
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd1,   8'd1,   8'd1);
    push_pixel(8'd200, 8'd200, 8'd50);
    push_pixel(8'd50,  8'd200, 8'd200);
    push_pixel(8'd200, 8'd50,  8'd200);
    push_pixel(8'd100, 8'd255, 8'd0);
    push_pixel(8'd0,   8'd255, 8'd100);
    push_pixel(8'd90,  8'd10,  8'd255);
    push_pixel(8'd10,  8'd90,  8'd255);
    push_pixel(8'd255, 8'd0,   8'd1);
  endtask

  // random pixels, biased toward ties, greys, dark and near-full channels
  task automatic test_random_pixels(input int count);
    chan_t r, g, b;
    int    kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      r = chan_t'($urandom_range(0, 255));
      g = chan_t'($urandom_range(0, 255));
      b = chan_t'($urandom_range(0, 255));
      if (kind < 10) begin
        // two channels equal
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end else if (kind < 15) begin
        g = r;
        b = r;
      end else if (kind < 27) begin
        r = chan_t'($urandom_range(0, 7));
        g = chan_t'($urandom_range(0, 7));
        b = chan_t'($urandom_range(0, 7));
      end else if (kind < 37) begin
        r = near_rail_chan();
        g = near_rail_chan();
        b = near_rail_chan();
      end
      push_pixel(r, g, b);
    end
  endtask

  // receiver stall pattern: modes of random length, from never stalling
  // to heavy random stalls and a fixed duty cycle
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= (cycle_count % 7) >= 4;
    endcase
  end

  // result checker: every result beat against the oldest expectation
  always @(posedge clk) begin
    hsv_t got;
    hsv_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{hue: hue_angle, sat: saturation_level, val: value_level};
      if (pending_hsv.size() == 0) begin
        hsv_mismatches++;
        if (hsv_mismatches <= REPORT_MAX)
          $display("%0t: result beat with none expected: hue %0d sat %0d val %0d",
                   $realtime, got.hue, got.sat, got.val);
      end else begin
        want = pending_hsv.pop_front();
        if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val) begin
          hsv_mismatches++;
          if (hsv_mismatches <= REPORT_MAX)
            $display("%0t: hue exp %0d got %0d, sat exp %0d got %0d, val exp %0d got %0d",
                     $realtime, want.hue, got.hue, want.sat, got.sat, want.val, got.val);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    red_byte   <= '0;
    green_byte <= '0;
    blue_byte  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_special_cases();
    test_random_pixels(RANDOM_PIXELS);
    in_valid <= 1'b0;

    // drain, then give the pipeline time to show any extra beat
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (hsv_mismatches == 0 && pending_hsv.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
